>>> design/tvsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types and codes for the tagged value stream decoder.
// ----------------------------------------------------------------------------
package tvsd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // event index limit after reset
    localparam logic [7:0] EVENT_COUNT_RESET = 8'd12;

    // token kinds
    localparam logic [2:0] KIND_EVENT  = 3'd0;
    localparam logic [2:0] KIND_BOOL   = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_BYTE   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    // error codes
    localparam logic [31:0] ERR_BAD_EVENT   = 32'd0;
    localparam logic [31:0] ERR_CUT_LENGTH  = 32'd1;
    localparam logic [31:0] ERR_CUT_PAYLOAD = 32'd2;

    // byte codes in normal mode
    localparam logic [7:0] CODE_SEPARATOR  = 8'd0;
    localparam logic [7:0] CODE_FALSE      = 8'd1;
    localparam logic [7:0] CODE_TRUE       = 8'd2;
    localparam logic [7:0] CODE_NUM_FIRST  = 8'd3;
    localparam logic [7:0] CODE_NUM_BASE   = 8'd2;
    localparam logic [7:0] CODE_STR_FIRST  = 8'd11;
    localparam logic [7:0] CODE_STR_LAST   = 8'd20;
    localparam logic [7:0] CODE_STR_BASE   = 8'd10;
    localparam logic [7:0] CODE_EMPTY_STR  = 8'd21;
    localparam logic [7:0] CODE_SMALL_BASE = 8'd100;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] token_value;
        logic        message_end;
    } t_out_item;

    // what the parser hands to the result register
    typedef struct packed {
        logic      have;
        t_out_item item;
    } t_parse_result;

endpackage
`default_nettype wire

>>> design/tvsd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsd_parser
// Parse state and per-byte decode: one input byte per step, at most one token.
// ----------------------------------------------------------------------------
module tvsd_parser #(
    parameter int VALUE_WIDTH = tvsd_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire tvsd_pkg::t_in_item      i_item,
    input  wire logic [7:0]              i_event_count,
    output tvsd_pkg::t_parse_result      o_result
);
    import tvsd_pkg::*;

    localparam int CW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [2:0] MODE_EVENT   = 3'd0;
    localparam logic [2:0] MODE_NORMAL  = 3'd1;
    localparam logic [2:0] MODE_NUMLEN  = 3'd2;
    localparam logic [2:0] MODE_STRLEN  = 3'd3;
    localparam logic [2:0] MODE_PAYLOAD = 3'd4;
    localparam logic [2:0] MODE_DROP    = 3'd5;

    logic [2:0]             r_mode, n_mode;
    logic [3:0]             r_left, n_left;
    logic [3:0]             r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [31:0]            r_pay, n_pay;

    logic [VALUE_WIDTH-1:0] acc_added;
    logic [31:0]            acc_low;
    logic [7:0]             b;
    logic                   eom;
    logic                   have;
    logic [2:0]             kind;
    logic [31:0]            val;

    assign b   = i_item.data_byte;
    assign eom = i_item.end_of_message;

    // byte lanes never overlap, so the add is a lane write
    for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_lane
        assign acc_added[k] = r_acc[k] | ((r_pos == 4'(k / 8)) & b[k % 8]);
    end

    assign acc_low = 32'(acc_added[CW-1:0]);

    always_comb begin
        n_mode = r_mode;
        n_left = r_left;
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_pay  = r_pay;
        have   = 1'b0;
        kind   = KIND_END;
        val    = 32'd0;
        unique case (r_mode)
            MODE_EVENT: begin
                have = 1'b1;
                if (b < i_event_count) begin
                    kind   = KIND_EVENT;
                    val    = 32'(b);
                    n_mode = MODE_NORMAL;
                end else begin
                    kind   = KIND_ERROR;
                    val    = ERR_BAD_EVENT;
                    n_mode = MODE_DROP;
                end
            end
            MODE_NORMAL: begin
                if (b == CODE_SEPARATOR) begin
                    n_mode = MODE_EVENT;
                end else if (b == CODE_FALSE || b == CODE_TRUE) begin
                    have = 1'b1;
                    kind = KIND_BOOL;
                    val  = (b == CODE_TRUE) ? 32'd1 : 32'd0;
                end else if (b == CODE_EMPTY_STR) begin
                    have = 1'b1;
                    kind = KIND_STRING;
                end else if (b >= CODE_NUM_FIRST && b <= CODE_STR_LAST) begin
                    if (b >= CODE_STR_FIRST) begin
                        n_mode = MODE_STRLEN;
                        n_left = 4'(b - CODE_STR_BASE);
                    end else begin
                        n_mode = MODE_NUMLEN;
                        n_left = 4'(b - CODE_NUM_BASE);
                    end
                    n_pos = 4'd0;
                    n_acc = '0;
                    if (eom) begin
                        have = 1'b1;
                        kind = KIND_ERROR;
                        val  = ERR_CUT_LENGTH;
                    end
                end else if (b >= CODE_SMALL_BASE) begin
                    have = 1'b1;
                    kind = KIND_NUMBER;
                    val  = 32'(b - CODE_SMALL_BASE);
                end
            end
            MODE_NUMLEN, MODE_STRLEN: begin
                n_acc  = acc_added;
                n_pos  = r_pos + 4'd1;
                n_left = r_left - 4'd1;
                if (r_left != 4'd1) begin
                    if (eom) begin
                        have = 1'b1;
                        kind = KIND_ERROR;
                        val  = ERR_CUT_LENGTH;
                    end
                end else if (r_mode == MODE_NUMLEN) begin
                    have   = 1'b1;
                    kind   = KIND_NUMBER;
                    val    = acc_low;
                    n_mode = MODE_NORMAL;
                end else begin
                    have = 1'b1;
                    if (acc_low != 32'd0 && eom) begin
                        kind = KIND_ERROR;
                        val  = ERR_CUT_PAYLOAD;
                    end else begin
                        kind   = KIND_STRING;
                        val    = acc_low;
                        n_pay  = acc_low;
                        n_mode = (acc_low != 32'd0) ? MODE_PAYLOAD : MODE_NORMAL;
                    end
                end
            end
            MODE_PAYLOAD: begin
                have  = 1'b1;
                n_pay = r_pay - 32'd1;
                if (r_pay != 32'd1 && eom) begin
                    kind = KIND_ERROR;
                    val  = ERR_CUT_PAYLOAD;
                end else begin
                    kind = KIND_BYTE;
                    val  = 32'(b);
                    if (r_pay == 32'd1) begin
                        n_mode = MODE_NORMAL;
                    end
                end
            end
            default: begin
                // drop mode: discard until the message ends
            end
        endcase
        if (eom) begin
            if (!have) begin
                have = 1'b1;
                kind = KIND_END;
                val  = 32'd0;
            end
            n_mode = MODE_EVENT;
            n_left = 4'd0;
            n_pos  = 4'd0;
            n_acc  = '0;
            n_pay  = 32'd0;
        end
    end

    assign o_result.have             = have;
    assign o_result.item.token_kind  = kind;
    assign o_result.item.token_value = val;
    assign o_result.item.message_end = eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EVENT;
            r_left <= 4'd0;
            r_pos  <= 4'd0;
            r_acc  <= '0;
            r_pay  <= 32'd0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_pay  <= n_pay;
        end
    end

    a_eom_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.end_of_message) |=> (r_mode == MODE_EVENT))
        else $error("parser not back to event mode after end of message");

    a_length_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUMLEN || r_mode == MODE_STRLEN) |-> (r_left != 4'd0))
        else $error("length field with no bytes left");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PAYLOAD) |-> (r_pay != 32'd0))
        else $error("payload mode with no bytes left");

endmodule
`default_nettype wire

>>> design/tvsd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsd_out_stage
// Result register: holds a token until the downstream side takes it.
// ----------------------------------------------------------------------------
module tvsd_out_stage (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire tvsd_pkg::t_parse_result i_result,
    input  wire logic                    i_out_stall,
    output logic                         o_free,
    output logic                         o_out_valid,
    output tvsd_pkg::t_out_item          o_out_data
);
    import tvsd_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.have;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.have) begin
            r_item <= i_result.item;
        end
    end

endmodule
`default_nettype wire

>>> design/tagged_value_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder
// Turns a byte stream of tagged values into event, bool, number, string,
// byte, error and end tokens, at most one token per byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_stall     i_in_data   (t_in_item)
//  out       output     o_out_valid / i_out_stall   o_out_data  (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data  (event_count)
//
// one byte per cycle sustained while the output does not stall; a token is held
// in the input register, then in the result register, from which it is valid
// the parse state updates on the same edge that loads the result register
// reset is synchronous and active low; event_count returns to 12
// a held result stalls the parser, and the input side once the input register
// holds a byte
// ----------------------------------------------------------------------------
module tagged_value_stream_decoder #(
    parameter int VALUE_WIDTH = tvsd_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tvsd_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tvsd_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);
    import tvsd_pkg::*;

    logic          r_in_valid, n_in_valid;
    t_in_item      r_in_item;
    logic [7:0]    r_event_count;
    logic          out_free;
    logic          step;
    logic          in_take;
    t_parse_result result;

    assign o_cfg_ready = 1'b1;
    assign step        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !step;
    assign in_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_event_count <= EVENT_COUNT_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_event_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
    end

    tvsd_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in_item),
        .i_event_count (r_event_count),
        .o_result      (result)
    );

    tvsd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
